// ===== rtl/quaternion_product_and_rotate_defines.svh =====
// Assertion macros shared by the quaternion product and rotate block.
`ifndef QUATERNION_PRODUCT_AND_ROTATE_DEFINES_SVH
`define QUATERNION_PRODUCT_AND_ROTATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define QPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define QPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qpr_pkg.sv =====
// Shared types and constants for the quaternion product and rotate block.
package qpr_pkg;

    localparam int COMP_W = 16;
    localparam int FRAC_W = 14;
    // Operands carry one extra bit so the negated conjugate stays exact.
    localparam int OPER_W = COMP_W + 1;
    localparam int PROD_W = 2 * OPER_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_W = 3;
    localparam int NUM_LANES = 4;
    localparam int NUM_TERMS = 4;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [OPER_W-1:0] oper_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    typedef enum logic
    {
        OP_PRODUCT = 1'b0,
        OP_ROTATE  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t   operation;
        comp_t a_x;
        comp_t a_y;
        comp_t a_z;
        comp_t a_w;
        comp_t b_x;
        comp_t b_y;
        comp_t b_z;
        comp_t b_w;
    } in_word_t;

    typedef struct packed
    {
        comp_t r_x;
        comp_t r_y;
        comp_t r_z;
        comp_t r_w;
        logic  overflow;
    } out_word_t;

    typedef struct packed
    {
        oper_t x;
        oper_t y;
        oper_t z;
        oper_t w;
    } quat_t;

    // Load strobes for the two register ranks of a lane.
    typedef struct packed
    {
        logic mul;
        logic sum;
    } stage_en_t;

    // Bit k set: term k of the lane is subtracted.
    localparam logic [NUM_TERMS-1:0] LANE_NEG [NUM_LANES] =
        '{4'b1000, 4'b1000, 4'b1000, 4'b1110};

endpackage

// ===== rtl/quaternion_product_and_rotate.sv =====
// Quaternion Hamilton product and vector rotation, top level.
// Takes one word per cycle while the output side is ready and returns one
// word per word. Two Hamilton units of four component lanes each (32
// multipliers of 17 by 17 bits) run one after the other: the first forms a*b
// (or a*(v,0) for a rotation), the second forms t*conj(a); every lane has a
// product rank and a sum/round/saturate rank, and a final register merges
// lane results and overflow flags. Products are summed exactly, rounded to
// nearest with ties upward at 14 fraction bits and saturated to 16 bits; a
// rotation also rounds and saturates t, and its overflow covers t, including
// t's scalar. A rotation returns r_w = 0.
`include "quaternion_product_and_rotate_defines.svh"

module quaternion_product_and_rotate
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qpr_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qpr_pkg::out_word_t out_data
);

    logic en1, en2, en3, en4, en_out;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    qpr_pkg::stage_en_t en_pass1;
    qpr_pkg::stage_en_t en_pass2;

    qpr_pkg::op_t   s1_op_reg, s2_op_reg, s3_op_reg, s4_op_reg;
    qpr_pkg::quat_t s1_a_reg, s2_a_reg;
    qpr_pkg::comp_t s3_t_reg [qpr_pkg::NUM_LANES];
    qpr_pkg::comp_t s4_t_reg [qpr_pkg::NUM_LANES];
    logic           s3_ovf_reg, s4_ovf_reg;

    qpr_pkg::quat_t p1, q1, p2, q2;
    qpr_pkg::comp_t t1 [qpr_pkg::NUM_LANES];
    qpr_pkg::comp_t r2 [qpr_pkg::NUM_LANES];
    logic [qpr_pkg::NUM_LANES-1:0] ovf1, ovf2;

    qpr_pkg::out_word_t out_next;
    qpr_pkg::out_word_t out_data_reg;

    // Advance a stage when it is empty or the one after it advances.
    assign en_out = !out_valid_reg || out_ready;
    assign en4    = !v4_reg || en_out;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign in_ready = en1;

    assign en_pass1 = '{mul: en1, sum: en2};
    assign en_pass2 = '{mul: en3, sum: en4};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    // First pass: a * b, with b's scalar dropped for a rotation.
    always_comb
    begin
        p1.x = qpr_pkg::oper_t'(in_data.a_x);
        p1.y = qpr_pkg::oper_t'(in_data.a_y);
        p1.z = qpr_pkg::oper_t'(in_data.a_z);
        p1.w = qpr_pkg::oper_t'(in_data.a_w);
        q1.x = qpr_pkg::oper_t'(in_data.b_x);
        q1.y = qpr_pkg::oper_t'(in_data.b_y);
        q1.z = qpr_pkg::oper_t'(in_data.b_z);
        q1.w = (in_data.operation == qpr_pkg::OP_ROTATE) ? '0
                                                         : qpr_pkg::oper_t'(in_data.b_w);
    end

    qpr_hamilton u_pass1
    (
        .clk (clk),
        .en  (en_pass1),
        .p   (p1),
        .q   (q1),
        .res (t1),
        .ovf (ovf1)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg <= in_data.operation;
            s1_a_reg  <= p1;
        end
        if (en2)
        begin
            s2_op_reg <= s1_op_reg;
            s2_a_reg  <= s1_a_reg;
        end
    end

    // Second pass: t * conj(a), conjugate kept exact in the wider operand.
    always_comb
    begin
        p2.x = qpr_pkg::oper_t'(t1[qpr_pkg::LANE_X]);
        p2.y = qpr_pkg::oper_t'(t1[qpr_pkg::LANE_Y]);
        p2.z = qpr_pkg::oper_t'(t1[qpr_pkg::LANE_Z]);
        p2.w = qpr_pkg::oper_t'(t1[qpr_pkg::LANE_W]);
        q2.x = -s2_a_reg.x;
        q2.y = -s2_a_reg.y;
        q2.z = -s2_a_reg.z;
        q2.w = s2_a_reg.w;
    end

    qpr_hamilton u_pass2
    (
        .clk (clk),
        .en  (en_pass2),
        .p   (p2),
        .q   (q2),
        .res (r2),
        .ovf (ovf2)
    );

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_op_reg  <= s2_op_reg;
            s3_t_reg   <= t1;
            s3_ovf_reg <= |ovf1;
        end
        if (en4)
        begin
            s4_op_reg  <= s3_op_reg;
            s4_t_reg   <= s3_t_reg;
            s4_ovf_reg <= s3_ovf_reg;
        end
    end

    // Merge lanes: pick the pass that holds the answer, fold overflow flags.
    always_comb
    begin
        if (s4_op_reg == qpr_pkg::OP_ROTATE)
        begin
            out_next.r_x      = r2[qpr_pkg::LANE_X];
            out_next.r_y      = r2[qpr_pkg::LANE_Y];
            out_next.r_z      = r2[qpr_pkg::LANE_Z];
            out_next.r_w      = '0;
            out_next.overflow = s4_ovf_reg || ovf2[qpr_pkg::LANE_X]
                                || ovf2[qpr_pkg::LANE_Y] || ovf2[qpr_pkg::LANE_Z];
        end
        else
        begin
            out_next.r_x      = s4_t_reg[qpr_pkg::LANE_X];
            out_next.r_y      = s4_t_reg[qpr_pkg::LANE_Y];
            out_next.r_z      = s4_t_reg[qpr_pkg::LANE_Z];
            out_next.r_w      = s4_t_reg[qpr_pkg::LANE_W];
            out_next.overflow = s4_ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && v4_reg)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `QPR_ASSERT_NEXT(a_accept_fills_stage1, in_valid && in_ready, v1_reg, "accepted word lost at entry")
    `QPR_ASSERT_NEXT(a_stall_keeps_last, v4_reg && !en_out, v4_reg, "last stage dropped a word while stalled")
    `QPR_ASSERT_NEXT(a_rotate_scalar_zero, v4_reg && en_out && s4_op_reg == qpr_pkg::OP_ROTATE, out_valid && out_data.r_w == '0, "rotation word left without zero scalar")
    `QPR_ASSERT_SAME(a_ready_when_empty, !v1_reg, in_ready, "entry stage empty but not ready")

endmodule

// ===== rtl/qpr_lane.sv =====
// One component lane: four products, signed sum, round to nearest and saturate.
module qpr_lane
(
    input  logic                                 clk,
    input  qpr_pkg::stage_en_t                   en,
    input  logic [qpr_pkg::NUM_TERMS-1:0]        neg,
    input  qpr_pkg::oper_t                       lhs [qpr_pkg::NUM_TERMS],
    input  qpr_pkg::oper_t                       rhs [qpr_pkg::NUM_TERMS],
    output qpr_pkg::comp_t                       res,
    output logic                                 ovf
);

    localparam qpr_pkg::acc_t ACC_HALF = qpr_pkg::acc_t'(1) <<< (qpr_pkg::FRAC_W - 1);
    localparam qpr_pkg::comp_t COMP_MAX = {1'b0, {(qpr_pkg::COMP_W-1){1'b1}}};
    localparam qpr_pkg::comp_t COMP_MIN = {1'b1, {(qpr_pkg::COMP_W-1){1'b0}}};

    qpr_pkg::prod_t prod_reg [qpr_pkg::NUM_TERMS];
    qpr_pkg::acc_t  acc;
    qpr_pkg::acc_t  rnd;
    qpr_pkg::acc_t  shifted;
    logic [qpr_pkg::ACC_W-qpr_pkg::COMP_W:0] hi_bits;
    qpr_pkg::comp_t res_next;
    logic           ovf_next;
    qpr_pkg::comp_t res_reg;
    logic           ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            for (int k = 0; k < qpr_pkg::NUM_TERMS; k++)
            begin
                prod_reg[k] <= qpr_pkg::prod_t'(lhs[k]) * qpr_pkg::prod_t'(rhs[k]);
            end
        end
    end

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < qpr_pkg::NUM_TERMS; k++)
        begin
            if (neg[k])
            begin
                acc = acc - qpr_pkg::acc_t'(prod_reg[k]);
            end
            else
            begin
                acc = acc + qpr_pkg::acc_t'(prod_reg[k]);
            end
        end
        rnd     = acc + ACC_HALF;
        shifted = rnd >>> qpr_pkg::FRAC_W;
        hi_bits = shifted[qpr_pkg::ACC_W-1:qpr_pkg::COMP_W-1];
        // Fits only when every bit above the kept sign matches it.
        if ((&hi_bits) || !(|hi_bits))
        begin
            res_next = shifted[qpr_pkg::COMP_W-1:0];
            ovf_next = 1'b0;
        end
        else
        begin
            res_next = shifted[qpr_pkg::ACC_W-1] ? COMP_MIN : COMP_MAX;
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            res_reg <= res_next;
            ovf_reg <= ovf_next;
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

// ===== rtl/qpr_hamilton.sv =====
// Hamilton product p*q over four parallel component lanes.
module qpr_hamilton
(
    input  logic                              clk,
    input  qpr_pkg::stage_en_t                en,
    input  qpr_pkg::quat_t                    p,
    input  qpr_pkg::quat_t                    q,
    output qpr_pkg::comp_t                    res [qpr_pkg::NUM_LANES],
    output logic [qpr_pkg::NUM_LANES-1:0]     ovf
);

    qpr_pkg::oper_t lhs [qpr_pkg::NUM_LANES][qpr_pkg::NUM_TERMS];
    qpr_pkg::oper_t rhs [qpr_pkg::NUM_LANES][qpr_pkg::NUM_TERMS];

    always_comb
    begin
        // x = pw*qx + qw*px + py*qz - pz*qy
        lhs[qpr_pkg::LANE_X] = '{p.w, q.w, p.y, p.z};
        rhs[qpr_pkg::LANE_X] = '{q.x, p.x, q.z, q.y};
        // y = pw*qy + qw*py + pz*qx - px*qz
        lhs[qpr_pkg::LANE_Y] = '{p.w, q.w, p.z, p.x};
        rhs[qpr_pkg::LANE_Y] = '{q.y, p.y, q.x, q.z};
        // z = pw*qz + qw*pz + px*qy - py*qx
        lhs[qpr_pkg::LANE_Z] = '{p.w, q.w, p.x, p.y};
        rhs[qpr_pkg::LANE_Z] = '{q.z, p.z, q.y, q.x};
        // w = pw*qw - px*qx - py*qy - pz*qz
        lhs[qpr_pkg::LANE_W] = '{p.w, p.x, p.y, p.z};
        rhs[qpr_pkg::LANE_W] = '{q.w, q.x, q.y, q.z};
    end

    for (genvar i = 0; i < qpr_pkg::NUM_LANES; i++)
    begin : g_lane
        qpr_lane u_lane
        (
            .clk (clk),
            .en  (en),
            .neg (qpr_pkg::LANE_NEG[i]),
            .lhs (lhs[i]),
            .rhs (rhs[i]),
            .res (res[i]),
            .ovf (ovf[i])
        );
    end

endmodule

// ===== dv/tb_quaternion_product_and_rotate.sv =====
// Self-checking testbench for the quaternion product and rotate block.
`timescale 1ns / 1ps

module tb_quaternion_product_and_rotate;

    localparam int     RANDOM_WORDS = 700;
    localparam int     QUIET_TAIL   = 100;
    localparam int     DRAIN_CYCLES = 20;
    localparam longint COMP_MAX     = (64'sd1 <<< (qpr_pkg::COMP_W - 1)) - 1;
    localparam longint COMP_MIN     = -COMP_MAX - 1;
    localparam qpr_pkg::comp_t Q_ONE = qpr_pkg::comp_t'(1 << qpr_pkg::FRAC_W);
    localparam qpr_pkg::comp_t Q_MAX = qpr_pkg::comp_t'(COMP_MAX);
    localparam qpr_pkg::comp_t Q_MIN = qpr_pkg::comp_t'(COMP_MIN);

    // Full-precision quaternion used by the predictor.
    typedef struct packed
    {
        longint x;
        longint y;
        longint z;
        longint w;
    } wide_quat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    qpr_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    qpr_pkg::out_word_t out_data;

    qpr_pkg::in_word_t  pending_words[$];
    qpr_pkg::out_word_t expected_quats[$];
    bit        in_taken = 1'b0;
    int        send_gap = 0;
    int        sink_stall = 0;
    int        fail_count = 0;
    int        product_count = 0;
    int        rotate_count = 0;
    int        checked_count = 0;
    int        overflow_count = 0;

    quaternion_product_and_rotate u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Round to nearest (ties up) at the fraction point, then clamp.
    function automatic longint round_saturate(input longint acc, inout bit ovf);
        longint v;
        v = (acc + (64'sd1 <<< (qpr_pkg::FRAC_W - 1))) >>> qpr_pkg::FRAC_W;
        if (v > COMP_MAX)
        begin
            ovf = 1'b1;
            return COMP_MAX;
        end
        if (v < COMP_MIN)
        begin
            ovf = 1'b1;
            return COMP_MIN;
        end
        return v;
    endfunction

    function automatic wide_quat_t hamilton_product(input wide_quat_t p, input wide_quat_t q,
                                                    input bit with_w, inout bit ovf);
        longint     px, py, pz, pw, qx, qy, qz, qw;
        wide_quat_t r;
        px = p.x; py = p.y; pz = p.z; pw = p.w;
        qx = q.x; qy = q.y; qz = q.z; qw = q.w;
        r.x = round_saturate(pw * qx + qw * px + py * qz - pz * qy, ovf);
        r.y = round_saturate(pw * qy + qw * py + pz * qx - px * qz, ovf);
        r.z = round_saturate(pw * qz + qw * pz + px * qy - py * qx, ovf);
        r.w = with_w ? round_saturate(pw * qw - px * qx - py * qy - pz * qz, ovf) : 0;
        return r;
    endfunction

    function automatic qpr_pkg::out_word_t predict_quat_result(input qpr_pkg::in_word_t w);
        wide_quat_t         qa, qb, qt, qc, qr;
        bit                 ovf;
        qpr_pkg::out_word_t res;
        ovf = 1'b0;
        qa.x = longint'($signed(w.a_x));
        qa.y = longint'($signed(w.a_y));
        qa.z = longint'($signed(w.a_z));
        qa.w = longint'($signed(w.a_w));
        qb.x = longint'($signed(w.b_x));
        qb.y = longint'($signed(w.b_y));
        qb.z = longint'($signed(w.b_z));
        qb.w = longint'($signed(w.b_w));
        if (w.operation == qpr_pkg::OP_PRODUCT)
        begin
            qr = hamilton_product(qa, qb, 1'b1, ovf);
        end
        else
        begin
            // Rotate: t = a*(v,0), then t*conj(a); conj(a) kept exact.
            qb.w = 0;
            qt = hamilton_product(qa, qb, 1'b1, ovf);
            qc.x = -qa.x;
            qc.y = -qa.y;
            qc.z = -qa.z;
            qc.w = qa.w;
            qr = hamilton_product(qt, qc, 1'b0, ovf);
        end
        res.r_x = qr.x[qpr_pkg::COMP_W-1:0];
        res.r_y = qr.y[qpr_pkg::COMP_W-1:0];
        res.r_z = qr.z[qpr_pkg::COMP_W-1:0];
        res.r_w = qr.w[qpr_pkg::COMP_W-1:0];
        res.overflow = ovf;
        return res;
    endfunction

    function automatic qpr_pkg::in_word_t make_word(input qpr_pkg::op_t op,
                                                    input qpr_pkg::comp_t ax,
                                                    input qpr_pkg::comp_t ay,
                                                    input qpr_pkg::comp_t az,
                                                    input qpr_pkg::comp_t aw,
                                                    input qpr_pkg::comp_t bx,
                                                    input qpr_pkg::comp_t by,
                                                    input qpr_pkg::comp_t bz,
                                                    input qpr_pkg::comp_t bw);
        qpr_pkg::in_word_t w;
        w.operation = op;
        w.a_x = ax; w.a_y = ay; w.a_z = az; w.a_w = aw;
        w.b_x = bx; w.b_y = by; w.b_z = bz; w.b_w = bw;
        return w;
    endfunction

    // Draw a component: full range, unit range, small, or a corner code.
    function automatic qpr_pkg::comp_t rand_comp(input int kind);
        qpr_pkg::comp_t corners[7];
        corners = '{Q_MIN, Q_MIN + 16'sd1, -16'sd1, 16'sd0, 16'sd1, Q_ONE, Q_MAX};
        case (kind)
            0: return qpr_pkg::comp_t'($urandom);
            1: return qpr_pkg::comp_t'($urandom_range(0, 2 * 16384) - 16384);
            2: return qpr_pkg::comp_t'($urandom_range(0, 2 * 2048) - 2048);
            default: return corners[$urandom_range(0, 6)];
        endcase
    endfunction

    task automatic check_field(input string name, input qpr_pkg::comp_t want,
                               input qpr_pkg::comp_t got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: present words from the pending queue, insert idle and stall bursts.
    always @(negedge clk)
    begin
        bit quiet;
        quiet = pending_words.size() < QUIET_TAIL;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (send_gap > 0 && !quiet)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            if (sink_stall > 0 && !quiet)
            begin
                sink_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    sink_stall = $urandom_range(1, 15);
            end
        end
    end

    // Monitor: predict on each accepted input word, check each accepted result word.
    always @(posedge clk)
    begin
        qpr_pkg::out_word_t want;
        in_taken = rst_n && in_valid && in_ready;
        if (in_taken)
        begin
            expected_quats.push_back(predict_quat_result(in_data));
            if (in_data.operation == qpr_pkg::OP_ROTATE)
                rotate_count++;
            else
                product_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_quats.size() == 0)
            begin
                $error("result word %h with nothing expected", out_data);
                fail_count++;
            end
            else
            begin
                want = expected_quats.pop_front();
                check_field("r_x", want.r_x, out_data.r_x);
                check_field("r_y", want.r_y, out_data.r_y);
                check_field("r_z", want.r_z, out_data.r_z);
                check_field("r_w", want.r_w, out_data.r_w);
                if (want.overflow !== out_data.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d", want.overflow,
                           out_data.overflow);
                    fail_count++;
                end
                checked_count++;
                if (out_data.overflow)
                    overflow_count++;
            end
        end
    end

    initial
    begin
        int kind;
        qpr_pkg::op_t op;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words: zeros, identity, extremes, rounding ties, saturation.
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, 0, 0, 0, Q_ONE,
                                          1234, -5678, 9012, -3456));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, 0, 0, 0, Q_ONE,
                                          1234, -5678, 9012, Q_MAX));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, 0, 0, 11585, 11585,
                                          Q_ONE, 0, 0, 0));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, 0, 0, 0, 1,
                                          8192, -8192, 8191, 8193));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, 0, 0, 0, 1,
                                          -8193, 24576, -24576, -8192));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                          Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                          Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                          Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                          Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                          Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        // Intermediate scalar saturates while the vector part stays small.
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, Q_MIN, Q_MIN, Q_MIN, 0,
                                          Q_MAX, Q_MAX, Q_MAX, 0));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, Q_MIN, 0, 0, 0,
                                          0, Q_ONE, 0, 0));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, -1, -1, -1, -1,
                                          -1, -1, -1, -1));
        pending_words.push_back(make_word(qpr_pkg::OP_ROTATE, 1, -1, 1, -1,
                                          Q_MAX, Q_MIN, 1, -1));
        pending_words.push_back(make_word(qpr_pkg::OP_PRODUCT, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                                          Q_ONE, Q_ONE, Q_ONE, Q_ONE));

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            kind = $urandom_range(0, 3);
            op = $urandom_range(0, 1) ? qpr_pkg::OP_ROTATE : qpr_pkg::OP_PRODUCT;
            pending_words.push_back(make_word(op,
                rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind),
                rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind)));
        end

        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_quats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d product and %0d rotate words; checked %0d results.",
                 product_count, rotate_count, checked_count);
        $display("%0d results flagged overflow; %0d mismatches.", overflow_count, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
